// ===== rtl/lset_pkg.sv =====
// ----------------------------------------------------------------------------
// Link-state edge table package
// Shared sizes, codes and the record that a search probe carries through the
// chain of table cells.
// ----------------------------------------------------------------------------
package lset_pkg;

    localparam int ENTRIES     = 64;
    localparam int NODE_BITS   = 8;
    localparam int WEIGHT_BITS = 16;
    localparam int DIST_BITS   = 16;
    localparam int IDX_BITS    = $clog2(ENTRIES);
    localparam int CNT_BITS    = $clog2(ENTRIES + 1);
    localparam int ACTION_BITS = 2;
    localparam int STATUS_BITS = 3;

    typedef enum logic [ACTION_BITS-1:0] {
        ACT_SET    = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_QUERY  = 2'd2
    } action_t;

    typedef enum logic [STATUS_BITS-1:0] {
        STS_ADDED     = 3'd0,
        STS_UPDATED   = 3'd1,
        STS_REMOVED   = 3'd2,
        STS_NOT_FOUND = 3'd3,
        STS_FULL      = 3'd4,
        STS_QUERY     = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        CMT_ADD,
        CMT_UPDATE,
        CMT_REMOVE
    } commit_kind_t;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    // Search results gathered as the probe passes each cell.
    typedef struct packed {
        logic                   fwd_hit;
        logic [IDX_BITS-1:0]    fwd_idx;
        logic [WEIGHT_BITS-1:0] fwd_cost;
        logic                   rev_hit;
        logic [WEIGHT_BITS-1:0] rev_cost;
        logic                   free_hit;
        logic [IDX_BITS-1:0]    free_idx;
    } probe_t;

    // Table change broadcast to every cell at the end of a scan.
    typedef struct packed {
        logic                en;
        commit_kind_t        kind;
        logic [IDX_BITS-1:0] slot;
    } commit_t;

endpackage

// ===== rtl/lset_cell.sv =====
// ----------------------------------------------------------------------------
// Link-state edge table cell
// Holds one table entry, compares it against the passing probe and hands the
// updated probe to the next cell. Applies a broadcast commit aimed at its slot.
// ----------------------------------------------------------------------------
module lset_cell (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [lset_pkg::IDX_BITS-1:0]    cell_idx,
    input  logic [lset_pkg::NODE_BITS-1:0]   from_node,
    input  logic [lset_pkg::NODE_BITS-1:0]   to_node,
    input  logic [lset_pkg::WEIGHT_BITS-1:0] weight,
    input  logic                             probe_live_in,
    input  lset_pkg::probe_t                 probe_in,
    input  lset_pkg::commit_t                commit,
    output logic                             probe_live_out,
    output lset_pkg::probe_t                 probe_out
);

    logic                             valid_reg;
    logic                             valid_next;
    logic [lset_pkg::NODE_BITS-1:0]   src_reg;
    logic [lset_pkg::NODE_BITS-1:0]   dst_reg;
    logic [lset_pkg::WEIGHT_BITS-1:0] cost_reg;
    logic                             live_reg;
    lset_pkg::probe_t                 probe_reg;
    lset_pkg::probe_t                 probe_next;
    logic                             fwd_match;
    logic                             rev_match;
    logic                             hit_me;

    assign fwd_match = valid_reg && (src_reg == from_node) && (dst_reg == to_node);
    assign rev_match = valid_reg && (src_reg == to_node) && (dst_reg == from_node);
    assign hit_me    = commit.en && (commit.slot == cell_idx);

    always_comb
    begin
        probe_next = probe_in;
        if (fwd_match && !probe_in.fwd_hit)
        begin
            probe_next.fwd_hit  = 1'b1;
            probe_next.fwd_idx  = cell_idx;
            probe_next.fwd_cost = cost_reg;
        end
        if (rev_match && !probe_in.rev_hit)
        begin
            probe_next.rev_hit  = 1'b1;
            probe_next.rev_cost = cost_reg;
        end
        if (!valid_reg && !probe_in.free_hit)
        begin
            probe_next.free_hit = 1'b1;
            probe_next.free_idx = cell_idx;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (hit_me)
        begin
            unique case (commit.kind)
                lset_pkg::CMT_ADD:    valid_next = 1'b1;
                lset_pkg::CMT_REMOVE: valid_next = 1'b0;
                default:              valid_next = valid_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            live_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            live_reg  <= probe_live_in;
        end
    end

    always_ff @(posedge clk)
    begin
        probe_reg <= probe_next;
        if (hit_me && (commit.kind == lset_pkg::CMT_ADD))
        begin
            src_reg  <= from_node;
            dst_reg  <= to_node;
            cost_reg <= weight;
        end
        else if (hit_me && (commit.kind == lset_pkg::CMT_UPDATE))
        begin
            cost_reg <= weight;
        end
    end

    assign probe_live_out = live_reg;
    assign probe_out      = probe_reg;

endmodule

// ===== rtl/link_state_edge_table.sv =====
// ----------------------------------------------------------------------------
// Link-state edge table
// Bounded table of directed weighted edges with set, remove and query actions.
// ----------------------------------------------------------------------------
// One transaction is taken at a time: start is accepted while busy is low, and
// its single result appears on done for one cycle once the search probe has
// passed launch_reg, walked the row of 64 table cells one cell per clock and
// reached done_reg, which is loaded at the edge that writes the table change;
// busy drops at the same edge, so a new transaction may start in the cycle
// that shows the result. The receiver cannot stall, so results must be
// captured in the cycle done is high. The table comes up empty after reset
// with no clearing pass. The user is to write max_distance only while busy is
// low; the block itself does not enforce it.
module link_state_edge_table (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [lset_pkg::ACTION_BITS-1:0] action,
    input  logic [lset_pkg::NODE_BITS-1:0]   from_node,
    input  logic [lset_pkg::NODE_BITS-1:0]   to_node,
    input  logic [lset_pkg::WEIGHT_BITS-1:0] weight,
    input  logic                             cfg_we,
    input  logic [lset_pkg::DIST_BITS-1:0]   cfg_data,
    output logic                             done,
    output logic [lset_pkg::STATUS_BITS-1:0] status,
    output logic                             edge_found,
    output logic [lset_pkg::WEIGHT_BITS-1:0] edge_weight,
    output logic [lset_pkg::WEIGHT_BITS-1:0] pair_distance,
    output logic                             is_neighbour,
    output logic [lset_pkg::CNT_BITS-1:0]    entry_count
);

    lset_pkg::state_t                 state_reg;
    lset_pkg::state_t                 state_next;
    logic                             launch_reg;
    logic [lset_pkg::DIST_BITS-1:0]   max_dist_reg;
    logic [lset_pkg::CNT_BITS-1:0]    count_reg;
    logic [lset_pkg::CNT_BITS-1:0]    count_next;
    logic [lset_pkg::ACTION_BITS-1:0] act_reg;
    logic [lset_pkg::NODE_BITS-1:0]   from_reg;
    logic [lset_pkg::NODE_BITS-1:0]   to_reg;
    logic [lset_pkg::WEIGHT_BITS-1:0] weight_reg;

    logic                             done_reg;
    lset_pkg::status_t                status_reg;
    lset_pkg::status_t                status_next;
    logic                             found_reg;
    logic                             found_next;
    logic [lset_pkg::WEIGHT_BITS-1:0] eweight_reg;
    logic [lset_pkg::WEIGHT_BITS-1:0] eweight_next;
    logic [lset_pkg::WEIGHT_BITS-1:0] dist_reg;
    logic [lset_pkg::WEIGHT_BITS-1:0] dist_next;
    logic                             neigh_reg;
    logic                             neigh_next;

    logic                             accept;
    logic                             tail_live;
    lset_pkg::probe_t                 tail;
    lset_pkg::commit_t                commit;
    logic [lset_pkg::ENTRIES:0]       live_chain;
    lset_pkg::probe_t                 probe_chain [lset_pkg::ENTRIES+1];

    assign busy      = (state_reg != lset_pkg::ST_IDLE);
    assign accept    = start && !busy;
    assign tail_live = live_chain[lset_pkg::ENTRIES];
    assign tail      = probe_chain[lset_pkg::ENTRIES];

    // A fresh probe enters the first cell the cycle after acceptance, once the
    // key registers hold the new transaction.
    assign live_chain[0]  = launch_reg;
    assign probe_chain[0] = '0;

    for (genvar i = 0; i < lset_pkg::ENTRIES; i++)
    begin : g_cell
        lset_cell u_cell (
            .clk            (clk),
            .rst_n          (rst_n),
            .cell_idx       (lset_pkg::IDX_BITS'(i)),
            .from_node      (from_reg),
            .to_node        (to_reg),
            .weight         (weight_reg),
            .probe_live_in  (live_chain[i]),
            .probe_in       (probe_chain[i]),
            .commit         (commit),
            .probe_live_out (live_chain[i+1]),
            .probe_out      (probe_chain[i+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= lset_pkg::ST_IDLE;
            launch_reg   <= 1'b0;
            count_reg    <= '0;
            done_reg     <= 1'b0;
            max_dist_reg <= '1;
        end
        else
        begin
            state_reg  <= state_next;
            launch_reg <= accept;
            count_reg  <= count_next;
            done_reg   <= (state_reg == lset_pkg::ST_SCAN) && tail_live;
            if (cfg_we)
            begin
                max_dist_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg    <= action;
            from_reg   <= from_node;
            to_reg     <= to_node;
            weight_reg <= weight;
        end
        if (tail_live)
        begin
            status_reg  <= status_next;
            found_reg   <= found_next;
            eweight_reg <= eweight_next;
            dist_reg    <= dist_next;
            neigh_reg   <= neigh_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        status_next  = lset_pkg::STS_NOT_FOUND;
        found_next   = 1'b0;
        eweight_next = '0;
        dist_next    = '0;
        neigh_next   = 1'b0;
        commit.en    = 1'b0;
        commit.kind  = lset_pkg::CMT_UPDATE;
        commit.slot  = tail.fwd_idx;

        unique case (state_reg)
            lset_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = lset_pkg::ST_SCAN;
                end
            end
            lset_pkg::ST_SCAN:
            begin
                if (tail_live)
                begin
                    state_next = lset_pkg::ST_IDLE;
                    unique case (act_reg)
                        lset_pkg::ACT_SET:
                        begin
                            priority if (tail.fwd_hit)
                            begin
                                status_next = lset_pkg::STS_UPDATED;
                                commit.en   = 1'b1;
                            end
                            else if (tail.free_hit)
                            begin
                                status_next = lset_pkg::STS_ADDED;
                                commit.en   = 1'b1;
                                commit.kind = lset_pkg::CMT_ADD;
                                commit.slot = tail.free_idx;
                                count_next  = count_reg + 1'b1;
                            end
                            else
                            begin
                                status_next = lset_pkg::STS_FULL;
                            end
                        end
                        lset_pkg::ACT_REMOVE:
                        begin
                            if (tail.fwd_hit)
                            begin
                                status_next = lset_pkg::STS_REMOVED;
                                commit.en   = 1'b1;
                                commit.kind = lset_pkg::CMT_REMOVE;
                                count_next  = count_reg - 1'b1;
                            end
                        end
                        lset_pkg::ACT_QUERY:
                        begin
                            status_next = lset_pkg::STS_QUERY;
                            found_next  = tail.fwd_hit;
                            priority if (tail.fwd_hit)
                            begin
                                eweight_next = tail.fwd_cost;
                                dist_next    = tail.fwd_cost;
                            end
                            else if (tail.rev_hit)
                            begin
                                dist_next = tail.rev_cost;
                            end
                            else
                            begin
                                dist_next = max_dist_reg;
                            end
                            neigh_next = (from_reg != to_reg) && (tail.fwd_hit || tail.rev_hit);
                        end
                        default:
                        begin
                            status_next = lset_pkg::STS_NOT_FOUND;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = lset_pkg::ST_IDLE;
            end
        endcase
    end

    assign done          = done_reg;
    assign status        = status_reg;
    assign edge_found    = found_reg;
    assign edge_weight   = eweight_reg;
    assign pair_distance = dist_reg;
    assign is_neighbour  = neigh_reg;
    assign entry_count   = count_reg;

    // Only one probe may be in the chain at any time.
    assert property (@(posedge clk) disable iff (!rst_n) $onehot0(live_chain))
        else $error("more than one probe in the cell chain");

    // A result is only produced by a probe that reached the end of the chain.
    assert property (@(posedge clk) disable iff (!rst_n) done |-> $past(tail_live))
        else $error("result strobe without a completed scan");

    // The table is only changed when a probe finishes its scan.
    assert property (@(posedge clk) disable iff (!rst_n) commit.en |-> tail_live && busy)
        else $error("table commit outside the end of a scan");

    // The edge count never exceeds the table size.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= lset_pkg::CNT_BITS'(lset_pkg::ENTRIES))
        else $error("edge count above table size");

    // An accepted transaction launches a probe and holds the block busy.
    assert property (@(posedge clk) disable iff (!rst_n) accept |=> launch_reg && busy)
        else $error("accepted transaction did not launch a probe");

endmodule
